/* sv/ctdc_pkg.sv */
package ctdc_pkg;

  typedef enum logic [1:0] {
    KIND_PRECISE     = 2'd0,
    KIND_COARSE      = 2'd1,
    KIND_VERY_COARSE = 2'd2,
    KIND_COARSE_ALT  = 2'd3
  } kind_e;

  localparam logic [19:0] USEC_MAX       = 20'd999999;
  localparam logic [20:0] USEC_PER_SEC   = 21'd1000000;
  localparam logic [19:0] HALF_SEC_USEC  = 20'd500000;
  localparam logic [10:0] MS_PER_SEC     = 11'd1000;
  localparam logic [41:0] DELAY_MAX      = 42'h3FF_FFFF_FFFF;
  localparam logic [22:0] DELAY_SEC_MAX  = 23'd4398047;

  // reciprocals: floor(x / d) = (x * R) >> shift over the stated input range
  localparam logic [31:0] RECIP_1000_IV  = 32'd2199023256;  // 31-bit x, >> 41
  localparam logic [20:0] RECIP_1000_US  = 21'd1073742;     // 20-bit x, >> 30
  localparam logic [15:0] RECIP_20       = 16'd52429;       // 15-bit x, >> 20
  localparam logic [15:0] RECIP_25       = 16'd41944;       // 15-bit x, >> 20
  localparam logic [15:0] RECIP_125      = 16'd33555;       // 15-bit x, >> 22
  localparam logic [10:0] RECIP_25_MS    = 11'd1311;        // 10-bit x, >> 15
  localparam logic [10:0] RECIP_125_MS   = 11'd1049;        // 10-bit x, >> 17

  typedef struct packed {
    logic lt50;
    logic lt100;
    logic ge5000;
    logic d25;
    logic d50;
    logic d100;
    logic d200;
    logic d250;
    logic d500;
  } cflags_t;

  typedef struct packed {
    logic [32:0] sec;
    logic [19:0] usec;
  } tstamp_t;

  function automatic tstamp_t ts_add(tstamp_t t, logic [21:0] q, logic [19:0] r_us);
    logic [20:0] raw;
    logic        wrap;
    tstamp_t     res;
    raw      = 21'(t.usec) + 21'(r_us);
    wrap     = raw > 21'(USEC_MAX);
    res.usec = wrap ? 20'(raw - USEC_PER_SEC) : raw[19:0];
    res.sec  = t.sec + 33'(q) + 33'(wrap);
    return res;
  endfunction

  function automatic logic ts_less(tstamp_t a, tstamp_t b);
    return (a.sec < b.sec) || ((a.sec == b.sec) && (a.usec < b.usec));
  endfunction

endpackage

/* sv/coarse_timer_deadline_calc_unit.sv */
// Coarse timer deadline calculator.
// Input beat: start with interval_ms_i, timer_kind_i, the stored deadline
// (prev_when_sec_i/usec_i) and the current time (now_sec_i/usec_i). A beat is
// taken at every edge where start is high and busy is low; busy stays low,
// so a new beat can enter on every cycle.
// Result beat: done_o is high for exactly one cycle with the resolved kind,
// the updated deadline, the wake time and the delay in microseconds. The
// receiver cannot hold results off; each strobe is taken on its closing edge.
// Depth: a beat passes 13 register stages, S1 to S13, for every kind.
// Throughput is one beat per cycle; the depth is set by the chain of
// constant-reciprocal multipliers, the wide millisecond gap compare and
// the delay multiplier.
// Reset clears the valid bits of every stage; beats in flight are dropped
// and done_o is low until a new beat comes through.
module coarse_timer_deadline_calc_unit import ctdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [30:0] interval_ms_i,
  input  logic [1:0]  timer_kind_i,
  input  logic [31:0] prev_when_sec_i,
  input  logic [19:0] prev_when_usec_i,
  input  logic [31:0] now_sec_i,
  input  logic [19:0] now_usec_i,
  output logic        done_o,
  output logic [1:0]  resolved_kind_o,
  output logic [31:0] next_when_sec_o,
  output logic [19:0] next_when_usec_o,
  output logic [31:0] wake_sec_o,
  output logic [19:0] wake_usec_o,
  output logic [41:0] delay_usec_o
);

  localparam int unsigned NSTG    = 13;
  localparam int unsigned RND_LAT = 3;

  typedef struct packed {
    kind_e       kind;
    logic        nz;
    logic        lt1000;
    logic [31:0] ns;
    logic [19:0] nu;
    logic [21:0] q;
    logic [19:0] r_us;
    logic [9:0]  slack;
    cflags_t     fl;
  } ctx_t;

  // valid pipeline
  logic [NSTG-1:0] vld_d, vld_q;

  assign busy  = 1'b0;
  assign vld_d = {vld_q[NSTG-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // S1: kind, clamp, reciprocal products
  logic        coarse_req;
  kind_e       kind_res;
  logic [19:0] nu_sat, pu_sat;
  ctx_t        s1_ctx_d, s1_ctx_q;
  logic [62:0] s1_piv_d, s1_piv_q;
  logic [40:0] s1_pnu_d, s1_pnu_q, s1_ppu_d, s1_ppu_q;
  logic [30:0] s1_p20_d, s1_p20_q, s1_p25_d, s1_p25_q, s1_p125_d, s1_p125_q;
  logic [30:0] s1_iv_q;
  logic [31:0] s1_ps_q;
  logic [19:0] s1_pu_q;

  always_comb begin
    coarse_req = (timer_kind_i == KIND_COARSE) || (timer_kind_i == KIND_COARSE_ALT);
    if (coarse_req) begin
      if (interval_ms_i >= 31'd20000) begin
        kind_res = KIND_VERY_COARSE;
      end else if (interval_ms_i <= 31'd20) begin
        kind_res = KIND_PRECISE;
      end else begin
        kind_res = KIND_COARSE;
      end
    end else if (timer_kind_i == KIND_VERY_COARSE) begin
      kind_res = KIND_VERY_COARSE;
    end else begin
      kind_res = KIND_PRECISE;
    end
  end

  assign nu_sat = (now_usec_i > USEC_MAX) ? USEC_MAX : now_usec_i;
  assign pu_sat = (prev_when_usec_i > USEC_MAX) ? USEC_MAX : prev_when_usec_i;

  always_comb begin
    s1_ctx_d        = '0;
    s1_ctx_d.kind   = kind_res;
    s1_ctx_d.nz     = interval_ms_i != '0;
    s1_ctx_d.lt1000 = interval_ms_i < 31'd1000;
    s1_ctx_d.ns     = now_sec_i;
    s1_ctx_d.nu     = nu_sat;
  end

  assign s1_piv_d  = 63'(interval_ms_i) * 63'(RECIP_1000_IV);
  assign s1_pnu_d  = 41'(nu_sat) * 41'(RECIP_1000_US);
  assign s1_ppu_d  = 41'(pu_sat) * 41'(RECIP_1000_US);
  assign s1_p20_d  = 31'(interval_ms_i[14:0]) * 31'(RECIP_20);
  assign s1_p25_d  = 31'(interval_ms_i[14:0]) * 31'(RECIP_25);
  assign s1_p125_d = 31'(interval_ms_i[14:0]) * 31'(RECIP_125);

  // S2: quotients, ms timestamps, divisibility
  logic [21:0] q_iv;
  logic [31:0] rem_full;
  logic [9:0]  s2_r_d, s2_r_q;
  logic [9:0]  q25, now_ms, dl_ms;
  logic [7:0]  q125;
  logic [14:0] iv15;
  logic        d25, d125;
  cflags_t     fl;
  ctx_t        s2_ctx_d, s2_ctx_q;
  logic [41:0] s2_tn_d, s2_tn_q, s2_tw_d, s2_tw_q;
  logic [30:0] s2_iv_q;
  logic [31:0] s2_ps_q;
  logic [19:0] s2_pu_q;

  assign q_iv     = s1_piv_q[62:41];
  assign rem_full = {1'b0, s1_iv_q} - 32'(q_iv) * 32'd1000;
  assign s2_r_d   = rem_full[9:0];
  assign now_ms   = s1_pnu_q[39:30];
  assign dl_ms    = s1_ppu_q[39:30];
  assign s2_tn_d  = 42'(s1_ctx_q.ns) * 42'd1000 + 42'(now_ms);
  assign s2_tw_d  = 42'(s1_ps_q) * 42'd1000 + 42'(dl_ms);
  assign iv15     = s1_iv_q[14:0];
  assign q25      = s1_p25_q[29:20];
  assign q125     = s1_p125_q[29:22];
  assign d25      = (15'(q25) * 15'd25) == iv15;
  assign d125     = (15'(q125) * 15'd125) == iv15;

  always_comb begin
    fl.lt50   = s1_iv_q < 31'd50;
    fl.lt100  = s1_iv_q < 31'd100;
    fl.ge5000 = s1_iv_q >= 31'd5000;
    fl.d25    = d25;
    fl.d50    = d25 && !iv15[0];
    fl.d100   = d25 && (iv15[1:0] == 2'b00);
    fl.d200   = d25 && (iv15[2:0] == 3'b000);
    fl.d250   = d125 && !iv15[0];
    fl.d500   = d125 && (iv15[1:0] == 2'b00);
    s2_ctx_d       = s1_ctx_q;
    s2_ctx_d.q     = q_iv;
    s2_ctx_d.slack = s1_p20_q[29:20];
    s2_ctx_d.fl    = fl;
  end

  // S3: gap, interval in us
  ctx_t               s3_ctx_d, s3_ctx_q;
  logic signed [42:0] s3_gap_d, s3_gap_q;
  logic [33:0]        s3_iv6_d, s3_iv6_q;
  logic [31:0]        s3_ps_q;
  logic [19:0]        s3_pu_q;

  assign s3_gap_d = $signed({1'b0, s2_tw_q}) - $signed({1'b0, s2_tn_q});
  assign s3_iv6_d = 34'(s2_iv_q) * 34'd6;

  always_comb begin
    s3_ctx_d      = s2_ctx_q;
    s3_ctx_d.r_us = 20'(s2_r_q) * 20'd1000;
  end

  // S4: pull back a deadline that lies too far ahead
  logic signed [45:0] gap5;
  logic               too_far;
  tstamp_t            s4_dl_d, s4_dl_q;
  ctx_t               s4_ctx_q;

  assign gap5    = 46'(s3_gap_q) * 46'sd5;
  assign too_far = s3_ctx_q.nz && (s3_ctx_q.lt1000 ? (s3_gap_q > 43'sd1500)
                                                   : (gap5 > $signed(46'(s3_iv6_q))));
  assign s4_dl_d.sec  = too_far ? 33'(s3_ctx_q.ns) : 33'(s3_ps_q);
  assign s4_dl_d.usec = too_far ? s3_ctx_q.nu : s3_pu_q;

  // S5: advance by one interval
  tstamp_t     s5_a_d, s5_a_q, s5_b_d, s5_b_q, s5_dl_q;
  logic [32:0] s5_v_d, s5_v_q;
  ctx_t        s5_ctx_q;

  assign s5_a_d = ts_add(s4_dl_q, s4_ctx_q.q, s4_ctx_q.r_us);
  assign s5_b_d = ts_add({33'(s4_ctx_q.ns), s4_ctx_q.nu}, s4_ctx_q.q, s4_ctx_q.r_us);
  assign s5_v_d = s4_dl_q.sec + 33'(s4_dl_q.usec >= HALF_SEC_USEC) + 33'(s4_ctx_q.q);

  // S6: final stored deadline
  tstamp_t     now5, pc;
  logic [32:0] v2;
  tstamp_t     s6_dl_d, s6_dl_q;
  ctx_t        s6_ctx_q;

  assign now5 = {33'(s5_ctx_q.ns), s5_ctx_q.nu};
  assign pc   = ts_less(s5_a_q, now5) ? s5_b_q : s5_a_q;
  assign v2   = (s5_v_q <= 33'(s5_ctx_q.ns)) ? 33'(s5_ctx_q.ns) + 33'(s5_ctx_q.q) : s5_v_q;

  always_comb begin
    case (s5_ctx_q.kind)
      KIND_VERY_COARSE: s6_dl_d = {v2, 20'd0};
      KIND_PRECISE:     s6_dl_d = s5_ctx_q.nz ? pc : s5_dl_q;
      default:          s6_dl_d = pc;
    endcase
  end

  // S7..S9: coarse rounding of the wake millisecond
  logic [10:0] rnd_ms;
  ctx_t        dly_ctx_q [RND_LAT];
  tstamp_t     dly_dl_q  [RND_LAT];

  ctdc_round u_round (
    .clk_i   (clk_i),
    .usec_i  (s6_dl_q.usec),
    .slack_i (s6_ctx_q.slack),
    .flags_i (s6_ctx_q.fl),
    .ms_o    (rnd_ms)
  );

  // S10: rounded wake time
  ctx_t    c9;
  tstamp_t s10_w_d, s10_w_q, s10_dl_q;
  logic    s10_wlt_d, s10_wlt_q;
  ctx_t    s10_ctx_q;

  assign c9             = dly_ctx_q[RND_LAT-1];
  assign s10_w_d.sec    = dly_dl_q[RND_LAT-1].sec + 33'(rnd_ms == MS_PER_SEC);
  assign s10_w_d.usec   = (rnd_ms == MS_PER_SEC) ? '0 : 20'(rnd_ms) * 20'd1000;
  assign s10_wlt_d      = ts_less(s10_w_d, {33'(c9.ns), c9.nu});

  // S11: wake time by kind
  tstamp_t s11_wake_d, s11_wake_q, s11_dl_q;
  ctx_t    s11_ctx_q;

  always_comb begin
    case (s10_ctx_q.kind)
      KIND_COARSE: begin
        s11_wake_d = s10_wlt_q ? ts_add(s10_w_q, s10_ctx_q.q, s10_ctx_q.r_us) : s10_w_q;
      end
      KIND_VERY_COARSE: s11_wake_d = s10_dl_q;
      default: begin
        s11_wake_d = s10_ctx_q.nz ? s10_dl_q : {33'(s10_ctx_q.ns), s10_ctx_q.nu};
      end
    endcase
  end

  // S12: delay terms
  logic signed [34:0] sdiff;
  logic signed [20:0] s12_udiff_d, s12_udiff_q;
  logic               s12_neg_d, s12_neg_q, s12_big_d, s12_big_q;
  logic [42:0]        s12_prod_d, s12_prod_q;
  tstamp_t            s12_wake_q, s12_dl_q;
  kind_e              s12_kind_q;

  assign sdiff       = $signed({2'b00, s11_wake_q.sec}) - $signed({3'b000, s11_ctx_q.ns});
  assign s12_udiff_d = $signed({1'b0, s11_wake_q.usec}) - $signed({1'b0, s11_ctx_q.nu});
  assign s12_neg_d   = (sdiff < 35'sd0) || ((sdiff == 35'sd0) && (s12_udiff_d < 21'sd0));
  assign s12_big_d   = sdiff > $signed(35'(DELAY_SEC_MAX));
  assign s12_prod_d  = 43'(sdiff[22:0]) * 43'd1000000;

  // S13: output register
  logic signed [43:0] dsum;
  logic [41:0]        delay_d;
  tstamp_t            out_dl, out_wake;
  logic [1:0]         out_kind_q;
  logic [31:0]        out_nsec_q, out_wsec_q;
  logic [19:0]        out_nusec_q, out_wusec_q;
  logic [41:0]        out_delay_q;

  assign dsum = $signed({1'b0, s12_prod_q}) + 44'(s12_udiff_q);

  always_comb begin
    if (s12_neg_q) begin
      delay_d = '0;
    end else if (s12_big_q || (dsum > $signed({2'b00, DELAY_MAX}))) begin
      delay_d = DELAY_MAX;
    end else begin
      delay_d = dsum[41:0];
    end
    out_dl   = s12_dl_q;
    out_wake = s12_wake_q;
    if (s12_dl_q.sec[32]) begin
      out_dl = {33'h0_FFFF_FFFF, USEC_MAX};
    end
    if (s12_wake_q.sec[32]) begin
      out_wake = {33'h0_FFFF_FFFF, USEC_MAX};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ctx_q  <= s1_ctx_d;
    s1_piv_q  <= s1_piv_d;
    s1_pnu_q  <= s1_pnu_d;
    s1_ppu_q  <= s1_ppu_d;
    s1_p20_q  <= s1_p20_d;
    s1_p25_q  <= s1_p25_d;
    s1_p125_q <= s1_p125_d;
    s1_iv_q   <= interval_ms_i;
    s1_ps_q   <= prev_when_sec_i;
    s1_pu_q   <= pu_sat;

    s2_ctx_q <= s2_ctx_d;
    s2_r_q   <= s2_r_d;
    s2_tn_q  <= s2_tn_d;
    s2_tw_q  <= s2_tw_d;
    s2_iv_q  <= s1_iv_q;
    s2_ps_q  <= s1_ps_q;
    s2_pu_q  <= s1_pu_q;

    s3_ctx_q <= s3_ctx_d;
    s3_gap_q <= s3_gap_d;
    s3_iv6_q <= s3_iv6_d;
    s3_ps_q  <= s2_ps_q;
    s3_pu_q  <= s2_pu_q;

    s4_ctx_q <= s3_ctx_q;
    s4_dl_q  <= s4_dl_d;

    s5_ctx_q <= s4_ctx_q;
    s5_dl_q  <= s4_dl_q;
    s5_a_q   <= s5_a_d;
    s5_b_q   <= s5_b_d;
    s5_v_q   <= s5_v_d;

    s6_ctx_q <= s5_ctx_q;
    s6_dl_q  <= s6_dl_d;

    dly_ctx_q[0] <= s6_ctx_q;
    dly_dl_q[0]  <= s6_dl_q;
    for (int i = 1; i < RND_LAT; i++) begin
      dly_ctx_q[i] <= dly_ctx_q[i-1];
      dly_dl_q[i]  <= dly_dl_q[i-1];
    end

    s10_ctx_q <= c9;
    s10_dl_q  <= dly_dl_q[RND_LAT-1];
    s10_w_q   <= s10_w_d;
    s10_wlt_q <= s10_wlt_d;

    s11_ctx_q  <= s10_ctx_q;
    s11_dl_q   <= s10_dl_q;
    s11_wake_q <= s11_wake_d;

    s12_kind_q  <= s11_ctx_q.kind;
    s12_dl_q    <= s11_dl_q;
    s12_wake_q  <= s11_wake_q;
    s12_udiff_q <= s12_udiff_d;
    s12_neg_q   <= s12_neg_d;
    s12_big_q   <= s12_big_d;
    s12_prod_q  <= s12_prod_d;

    out_kind_q  <= s12_kind_q;
    out_nsec_q  <= out_dl.sec[31:0];
    out_nusec_q <= out_dl.usec;
    out_wsec_q  <= out_wake.sec[31:0];
    out_wusec_q <= out_wake.usec;
    out_delay_q <= delay_d;
  end

  assign done_o           = vld_q[NSTG-1];
  assign resolved_kind_o  = out_kind_q;
  assign next_when_sec_o  = out_nsec_q;
  assign next_when_usec_o = out_nusec_q;
  assign wake_sec_o       = out_wsec_q;
  assign wake_usec_o      = out_wusec_q;
  assign delay_usec_o     = out_delay_q;

endmodule

/* sv/ctdc_round.sv */
module ctdc_round import ctdc_pkg::*; (
  input  logic        clk_i,
  input  logic [19:0] usec_i,
  input  logic [9:0]  slack_i,
  input  cflags_t     flags_i,
  output logic [10:0] ms_o
);

  // stage A: ms of the deadline
  logic [40:0] a_pms_d, a_pms_q;
  logic [9:0]  a_slack_q;
  cflags_t     a_fl_q;

  assign a_pms_d = 41'(usec_i) * 41'(RECIP_1000_US);

  // stage B: window and quotients
  logic [9:0]  ms;
  logic [9:0]  b_lo_d, b_lo_q;
  logic [10:0] hisum;
  logic [10:0] b_hi_d, b_hi_q;
  logic [20:0] b_p25_d, b_p25_q;
  logic [19:0] b_p125_d, b_p125_q;
  logic [9:0]  b_ms_q;
  cflags_t     b_fl_q;

  assign ms       = a_pms_q[39:30];
  assign b_lo_d   = (ms > a_slack_q) ? ms - a_slack_q : '0;
  assign hisum    = 11'(ms) + 11'(a_slack_q);
  assign b_hi_d   = (hisum > MS_PER_SEC) ? MS_PER_SEC : hisum;
  assign b_p25_d  = 21'(ms) * 21'(RECIP_25_MS);
  assign b_p125_d = 20'(ms) * 20'(RECIP_125_MS);

  // stage C: pick the boundary
  logic [5:0]  q25;
  logic [2:0]  q125;
  logic [10:0] stepv, base, mid, upper, stepped, fixed_ms;
  logic        fixed;
  logic [10:0] c_ms_d, c_ms_q;

  assign q25  = b_p25_q[20:15];
  assign q125 = b_p125_q[19:17];

  always_comb begin
    stepv    = 11'd25;
    base     = 11'(q25) * 11'd25;
    fixed    = 1'b0;
    fixed_ms = '0;
    if (b_fl_q.lt100 && !b_fl_q.d25) begin
      fixed    = 1'b1;
      fixed_ms = b_fl_q.lt50 ? {1'b0, b_ms_q[9:2], b_ms_q[1] | q25[0], 1'b0}
                             : {1'b0, b_ms_q[9:3], b_ms_q[2] | q25[1], 2'b00};
    end else if (b_lo_q == '0) begin
      fixed    = 1'b1;
      fixed_ms = '0;
    end else if (b_hi_q == MS_PER_SEC) begin
      fixed    = 1'b1;
      fixed_ms = MS_PER_SEC;
    end else if (b_fl_q.d500) begin
      if (b_fl_q.ge5000) begin
        fixed    = 1'b1;
        fixed_ms = (b_ms_q >= 10'd500) ? b_hi_q : 11'(b_lo_q);
      end else begin
        stepv = 11'd500;
        base  = 11'(q125 >> 2) * 11'd500;
      end
    end else if (b_fl_q.d50) begin
      if (b_fl_q.d200) begin
        stepv = 11'd200;
        base  = 11'(q25 >> 3) * 11'd200;
      end else if (b_fl_q.d100) begin
        stepv = 11'd100;
        base  = 11'(q25 >> 2) * 11'd100;
      end else if (b_fl_q.d250) begin
        stepv = 11'd250;
        base  = 11'(q125 >> 1) * 11'd250;
      end else begin
        stepv = 11'd50;
        base  = 11'(q25 >> 1) * 11'd50;
      end
    end
    mid     = base + (stepv >> 1);
    upper   = base + stepv;
    stepped = (11'(b_ms_q) < mid) ? ((base > 11'(b_lo_q)) ? base : 11'(b_lo_q))
                                  : ((upper < b_hi_q) ? upper : b_hi_q);
    c_ms_d  = fixed ? fixed_ms : stepped;
  end

  always_ff @(posedge clk_i) begin
    a_pms_q   <= a_pms_d;
    a_slack_q <= slack_i;
    a_fl_q    <= flags_i;
    b_ms_q    <= ms;
    b_lo_q    <= b_lo_d;
    b_hi_q    <= b_hi_d;
    b_p25_q   <= b_p25_d;
    b_p125_q  <= b_p125_d;
    b_fl_q    <= a_fl_q;
    c_ms_q    <= c_ms_d;
  end

  assign ms_o = c_ms_q;

endmodule
